/* src/cslu_pkg.sv */
// Shared constants and types for the cyclic schedule interval lookup unit.
`timescale 1ns / 1ps

package cslu_pkg;

  // Default sizes of the schedule tables and of the time word.
  localparam int MAX_CYCLES_DEF    = 8;
  localparam int MAX_INTERVALS_DEF = 16;
  localparam int TIME_BITS_DEF     = 40;

  // Fixed field widths.
  localparam int LEN_W       = 16;
  localparam int UNITS_W     = 20;
  localparam int BASE_W      = 16;
  localparam int REP_W       = 16;
  localparam int CNT_W       = 5;
  localparam int AI_W        = 5;
  localparam int ACT_W       = 4;
  localparam int CYC_IDX_W   = 3;
  localparam int INT_IDX_W   = 4;
  localparam int CYC_TICKS_W = UNITS_W + BASE_W;
  localparam int DESC_W      = CNT_W + REP_W + UNITS_W;

  // Configuration port.
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;

  // Operation codes carried in tuser.
  typedef enum logic [1:0] {
    FUNC_LOAD_INTERVAL = 2'd0,
    FUNC_LOAD_CYCLE    = 2'd1,
    FUNC_QUERY         = 2'd2,
    FUNC_NEXT_EDGE     = 2'd3
  } func_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_BASE_UNIT = 2'd0;
  localparam logic [1:0] REG_START     = 2'd1;
  localparam logic [1:0] REG_STOP      = 2'd2;
  localparam logic [1:0] REG_ACTIVE    = 2'd3;

endpackage

/* src/cslu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cslu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/cyclic_schedule_interval_lookup_unit.sv */
// Cyclic schedule interval lookup: table loads, interval query and next-transition search.
// A load, or a query of a cycle not in use, goes straight to the result. A query past the repeat
// span stops at the span check; other queries run two passes of the bit-serial divider and then
// scan the intervals. A transition search does this for each active cycle in its span that has
// more than one interval. One item at a time; the next one is accepted after its result.
// Synchronous reset (rst) restores state, m_tvalid and configuration; the tables are not cleared.
`timescale 1ns / 1ps

module cyclic_schedule_interval_lookup_unit #(
  parameter int MAX_CYCLES    = cslu_pkg::MAX_CYCLES_DEF,
  parameter int MAX_INTERVALS = cslu_pkg::MAX_INTERVALS_DEF,
  parameter int TIME_BITS     = cslu_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tdata: cycle_index, interval_index, interval_units, interval_total,
  // repeat_value, cycle_units, query_time.
  input  logic [64+TIME_BITS-1:0]           s_tdata,
  // tuser: func.
  input  logic [1:0]                        s_tuser,
  // Result stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tdata: active_interval, delta_time, zero padding.
  output logic [((cslu_pkg::AI_W+TIME_BITS+7)/8)*8-1:0] m_tdata,
  // tuser: delta_valid.
  output logic                              m_tuser,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cslu_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cslu_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cslu_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int CW   = (MAX_CYCLES > 1) ? $clog2(MAX_CYCLES) : 1;
  localparam int IW   = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int KW   = CW + 1;
  localparam int NW   = IW + 1;
  localparam int LW   = cslu_pkg::CYC_TICKS_W;
  localparam int RLW  = cslu_pkg::REP_W - 1 + LW;
  localparam int SW   = cslu_pkg::LEN_W + IW + 1;
  localparam int PW   = SW + cslu_pkg::BASE_W;
  localparam int M1   = (RLW > TIME_BITS) ? RLW : TIME_BITS;
  localparam int M2   = (PW > LW) ? PW : LW;
  localparam int WW   = ((M1 > M2) ? M1 : M2) + 1;
  localparam int DVW  = (TIME_BITS > LW) ? TIME_BITS : LW;
  localparam int DCW  = $clog2(DVW + 1);
  localparam int OW   = ((cslu_pkg::AI_W + TIME_BITS + 7) / 8) * 8;
  localparam int IRAM_DEPTH = 1 << (CW + IW);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DESC_WAIT, ST_DESC, ST_REPMUL, ST_SPAN, ST_DIV, ST_DIV_DONE,
    ST_SCAN_WAIT, ST_SCAN, ST_PROD, ST_CAND, ST_NEXT_CYC, ST_FINISH
  } state_t;

  // Input field views.
  logic [cslu_pkg::CYC_IDX_W-1:0] in_cycle;
  logic [cslu_pkg::INT_IDX_W-1:0] in_interval;
  logic [cslu_pkg::LEN_W-1:0]     in_units;
  logic [cslu_pkg::CNT_W-1:0]     in_total;
  logic [cslu_pkg::REP_W-1:0]     in_repeat;
  logic [cslu_pkg::UNITS_W-1:0]   in_cycle_units;
  logic [TIME_BITS-1:0]           in_time;

  assign in_cycle       = s_tdata[2:0];
  assign in_interval    = s_tdata[6:3];
  assign in_units       = s_tdata[22:7];
  assign in_total       = s_tdata[27:23];
  assign in_repeat      = s_tdata[43:28];
  assign in_cycle_units = s_tdata[63:44];
  assign in_time        = s_tdata[64+TIME_BITS-1:64];

  // Configuration registers.
  logic [cslu_pkg::BASE_W-1:0] base_unit;
  logic [TIME_BITS-1:0]        start_t;
  logic [TIME_BITS-1:0]        stop_t;
  logic [cslu_pkg::ACT_W-1:0]  active;

  logic [cslu_pkg::BASE_W-1:0] base_eff;
  logic [KW-1:0]               used;

  assign base_eff = (base_unit == '0) ? cslu_pkg::BASE_W'(1) : base_unit;
  assign used     = (int'(active) > MAX_CYCLES) ? KW'(MAX_CYCLES) : KW'(active);

  // Sequencer registers.
  state_t                      state;
  cslu_pkg::func_t             func_q;
  logic [TIME_BITS-1:0]        time_q;
  logic [CW-1:0]               k;
  logic [LW-1:0]               cyc_len;
  logic [NW-1:0]               cnt;
  logic [cslu_pkg::REP_W-1:0]  rep;
  logic [RLW-1:0]              rep_len;
  logic [WW-1:0]               span_end;
  logic                        neg;
  logic                        div_pass;
  logic [DVW-1:0]              dvd;
  logic [LW:0]                 rem;
  logic [LW-1:0]               dvs;
  logic [DCW-1:0]              step;
  logic [LW-1:0]               off;
  logic [LW-1:0]               done_units;
  logic [SW-1:0]               sum;
  logic [IW-1:0]               scan_i;
  logic [PW-1:0]               prod;
  logic [WW-1:0]               best;
  logic                        found;
  logic [cslu_pkg::AI_W-1:0]   res_ai;
  logic [TIME_BITS-1:0]        res_delta;
  logic                        res_valid;

  // Memories.
  logic                         desc_we;
  logic [cslu_pkg::DESC_W-1:0]  desc_rdata;
  logic                         ival_we;
  logic [cslu_pkg::LEN_W-1:0]   ival_rdata;
  logic                         accept;
  logic                         out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign desc_we = accept && (s_tuser == cslu_pkg::FUNC_LOAD_CYCLE)
                   && (int'(in_cycle) < MAX_CYCLES);
  assign ival_we = accept && (s_tuser == cslu_pkg::FUNC_LOAD_INTERVAL)
                   && (int'(in_cycle) < MAX_CYCLES) && (int'(in_interval) < MAX_INTERVALS);

  cslu_ram #(
    .WIDTH(cslu_pkg::DESC_W),
    .DEPTH(1 << CW)
  ) u_desc_ram (
    .clk  (clk),
    .we   (desc_we),
    .waddr(CW'(in_cycle)),
    .wdata({in_total, in_repeat, in_cycle_units}),
    .raddr(k),
    .rdata(desc_rdata)
  );

  cslu_ram #(
    .WIDTH(cslu_pkg::LEN_W),
    .DEPTH(IRAM_DEPTH)
  ) u_ival_ram (
    .clk  (clk),
    .we   (ival_we),
    .waddr({CW'(in_cycle), IW'(in_interval)}),
    .wdata(in_units),
    .raddr({k, scan_i}),
    .rdata(ival_rdata)
  );

  // Datapath helpers for the current step.
  logic [LW:0]    div_shift;
  logic           div_ge;
  logic [LW-1:0]  off_calc;
  logic [SW-1:0]  sum_new;
  logic           rep_pos;
  logic [WW-1:0]  t_ext;
  logic [WW-1:0]  cand_d;
  logic [WW-1:0]  cand_lim;
  logic [WW-1:0]  time_mask_ext;

  always_comb begin
    div_shift     = {rem[LW-1:0], dvd[DVW-1]};
    div_ge        = div_shift >= {1'b0, dvs};
    off_calc      = neg ? ((rem == '0) ? '0 : (cyc_len - rem[LW-1:0])) : rem[LW-1:0];
    sum_new       = sum + SW'(ival_rdata);
    rep_pos       = !rep[cslu_pkg::REP_W-1] && (rep != '0);
    t_ext         = WW'(time_q);
    cand_d        = ((int'(scan_i) + 1) >= int'(cnt)) ? (WW'(cyc_len) - WW'(off))
                                                      : (WW'(prod) - WW'(off));
    cand_lim      = span_end - t_ext;
    time_mask_ext = WW'({TIME_BITS{1'b1}});
  end

  // Sequencer: one item at a time through descriptor read, divider and interval scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            func_q    <= cslu_pkg::func_t'(s_tuser);
            time_q    <= in_time;
            res_ai    <= '0;
            res_delta <= '0;
            res_valid <= 1'b0;
            found     <= 1'b0;
            best      <= '0;
            unique case (cslu_pkg::func_t'(s_tuser))
              cslu_pkg::FUNC_QUERY: begin
                if (int'(in_cycle) >= int'(used)) begin
                  res_ai <= '1;
                  state  <= ST_FINISH;
                end else begin
                  k     <= CW'(in_cycle);
                  state <= ST_DESC_WAIT;
                end
              end
              cslu_pkg::FUNC_NEXT_EDGE: begin
                k     <= '0;
                state <= (used == '0) ? ST_FINISH : ST_DESC_WAIT;
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_DESC_WAIT: begin
          state <= ST_DESC;
        end
        // Unpack the descriptor and form the cycle length in ticks.
        ST_DESC: begin
          cyc_len <= LW'(((desc_rdata[cslu_pkg::UNITS_W-1:0] == '0)
                          ? cslu_pkg::UNITS_W'(1) : desc_rdata[cslu_pkg::UNITS_W-1:0])
                         * base_eff);
          rep     <= desc_rdata[cslu_pkg::UNITS_W +: cslu_pkg::REP_W];
          if (desc_rdata[cslu_pkg::DESC_W-1 -: cslu_pkg::CNT_W] == '0) begin
            cnt <= NW'(1);
          end else if (int'(desc_rdata[cslu_pkg::DESC_W-1 -: cslu_pkg::CNT_W])
                       > MAX_INTERVALS) begin
            cnt <= NW'(MAX_INTERVALS);
          end else begin
            cnt <= NW'(desc_rdata[cslu_pkg::DESC_W-1 -: cslu_pkg::CNT_W]);
          end
          state <= ST_REPMUL;
        end
        ST_REPMUL: begin
          rep_len <= RLW'(rep[cslu_pkg::REP_W-2:0] * cyc_len);
          state   <= ST_SPAN;
        end
        // Decide whether the cycle is inside its span and start the modulo pass.
        ST_SPAN: begin
          neg      <= time_q < start_t;
          dvd      <= (time_q < start_t) ? DVW'(start_t - time_q) : DVW'(time_q - start_t);
          rem      <= '0;
          dvs      <= cyc_len;
          step     <= DCW'(DVW);
          div_pass <= 1'b0;
          span_end <= rep_pos ? WW'(rep_len) : WW'(stop_t);
          if (func_q == cslu_pkg::FUNC_QUERY) begin
            if (rep[cslu_pkg::REP_W-1] || (rep_pos && (WW'(time_q) < WW'(rep_len)))) begin
              state <= ST_DIV;
            end else begin
              res_ai <= cslu_pkg::AI_W'(cnt - NW'(1));
              state  <= ST_FINISH;
            end
          end else begin
            if ((t_ext < (rep_pos ? WW'(rep_len) : WW'(stop_t))) && (cnt > NW'(1))) begin
              state <= ST_DIV;
            end else begin
              state <= ST_NEXT_CYC;
            end
          end
        end
        // Restoring divider, one quotient bit per cycle.
        ST_DIV: begin
          rem  <= div_ge ? (div_shift - {1'b0, dvs}) : div_shift;
          dvd  <= {dvd[DVW-2:0], div_ge};
          step <= step - DCW'(1);
          if (step == DCW'(1)) begin
            state <= ST_DIV_DONE;
          end
        end
        ST_DIV_DONE: begin
          if (!div_pass) begin
            off      <= off_calc;
            dvd      <= DVW'(off_calc);
            rem      <= '0;
            dvs      <= LW'(base_eff);
            step     <= DCW'(DVW);
            div_pass <= 1'b1;
            state    <= ST_DIV;
          end else begin
            done_units <= dvd[LW-1:0];
            sum        <= '0;
            scan_i     <= '0;
            state      <= ST_SCAN_WAIT;
          end
        end
        ST_SCAN_WAIT: begin
          state <= ST_SCAN;
        end
        // Walk the cumulative interval lengths until one ends beyond the offset or the last is reached.
        ST_SCAN: begin
          sum <= sum_new;
          if ((WW'(done_units) >= WW'(sum_new)) && ((int'(scan_i) + 1) < int'(cnt))) begin
            scan_i <= scan_i + IW'(1);
            state  <= ST_SCAN_WAIT;
          end else if (func_q == cslu_pkg::FUNC_QUERY) begin
            res_ai <= cslu_pkg::AI_W'(scan_i);
            state  <= ST_FINISH;
          end else begin
            state <= ST_PROD;
          end
        end
        ST_PROD: begin
          prod  <= PW'(sum * base_eff);
          state <= ST_CAND;
        end
        // Keep the smallest candidate that lies before the end of its span.
        ST_CAND: begin
          if (cand_d < cand_lim) begin
            if (!found || (cand_d < best)) begin
              best <= cand_d;
            end
            found <= 1'b1;
          end
          state <= ST_NEXT_CYC;
        end
        ST_NEXT_CYC: begin
          if ((int'(k) + 1) >= int'(used)) begin
            state <= ST_FINISH;
          end else begin
            k     <= k + CW'(1);
            state <= ST_DESC_WAIT;
          end
        end
        // Hand the result to the output register once it is free.
        ST_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OW'({(found ? ((best > time_mask_ext) ? {TIME_BITS{1'b1}}
                                                             : best[TIME_BITS-1:0])
                                    : res_delta),
                             res_ai});
            m_tuser  <= found;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_unit <= cslu_pkg::BASE_W'(1);
      start_t   <= '0;
      stop_t    <= '0;
      active    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:3])
        cslu_pkg::REG_BASE_UNIT: base_unit <= pwdata[cslu_pkg::BASE_W-1:0];
        cslu_pkg::REG_START:     start_t   <= pwdata[TIME_BITS-1:0];
        cslu_pkg::REG_STOP:      stop_t    <= pwdata[TIME_BITS-1:0];
        cslu_pkg::REG_ACTIVE:    active    <= pwdata[cslu_pkg::ACT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[4:3])
      cslu_pkg::REG_BASE_UNIT: prdata = cslu_pkg::APB_DATA_W'(base_unit);
      cslu_pkg::REG_START:     prdata = cslu_pkg::APB_DATA_W'(start_t);
      cslu_pkg::REG_STOP:      prdata = cslu_pkg::APB_DATA_W'(stop_t);
      cslu_pkg::REG_ACTIVE:    prdata = cslu_pkg::APB_DATA_W'(active);
      default:                 prdata = '0;
    endcase
  end

  assign pready = 1'b1;

endmodule
